// ===== hw/rtl/bac_pkg.sv =====
// Shared types and constants for the brake actuator controller.
`default_nettype none
package bac_pkg;
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_SAMPLE = 3'd1;
  localparam logic [2:0] FUNC_CMD   = 3'd2;
  localparam logic [2:0] FUNC_ESTOP = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  localparam logic [2:0] MODE_RELEASED  = 3'd0;
  localparam logic [2:0] MODE_PUSHING   = 3'd1;
  localparam logic [2:0] MODE_PUSHED    = 3'd2;
  localparam logic [2:0] MODE_RELEASING = 3'd3;
  localparam logic [2:0] MODE_STOPPED   = 3'd4;

  localparam logic [2:0] REG_RELEASED = 3'd0;
  localparam logic [2:0] REG_PUSHED   = 3'd1;
  localparam logic [2:0] REG_TOL      = 3'd2;
  localparam logic [2:0] REG_DUTY     = 3'd3;
  localparam logic [2:0] REG_TIMEOUT  = 3'd4;
  localparam logic [2:0] REG_VMIN     = 3'd5;
  localparam logic [2:0] REG_VMAX     = 3'd6;
  localparam logic [2:0] REG_DEFEST   = 3'd7;

  localparam int CFG_W = 16;

  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] sample;
    logic        command;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  brake_mode;
    logic        motor_enable;
    logic        push_direction;
    logic [6:0]  duty_out;
    logic [15:0] time_to_end;
    logic [6:0]  position_percent;
    logic        error_flag;
    logic        clear_ok;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // apply the item's state update
    logic est_start; // start estimate divide
    logic pct_start; // start percent divide
    logic est_fin;   // write estimate from quotient
    logic res_load;  // capture result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_est;  // tick needs an estimate division
    logic div_busy;
  } dp_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bac_if.sv =====
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface bac_in_if import bac_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bac_out_if import bac_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bac_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module bac_div import bac_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [18:0] dividend,
  input  wire logic [12:0] divisor,
  output logic             busy,
  output logic [18:0]      quotient
);
  logic [18:0] q_r, q_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [12:0] d_r, d_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [13:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {rem_r, q_r[18]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; d_nxt = divisor; cnt_nxt = 5'd19; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[13]) begin
        rem_nxt = trial[12:0];
        q_nxt = {q_r[17:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[11:0], q_r[18]};
        q_nxt = {q_r[17:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
  end

  assign busy = busy_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

// ===== hw/rtl/bac_datapath.sv =====
// State, configuration registers, decisions and arithmetic for the controller.
`default_nettype none
module bac_datapath import bac_pkg::*; #(
  parameter int ERROR_LIMIT = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire in_item_t         item,
  input  wire dp_cmd_t          cmd,
  output dp_sts_t               sts,
  output out_item_t             result
);
  localparam logic [3:0] LIMIT = 4'(ERROR_LIMIT);

  logic [11:0] rel_r, push_r, vmin_r, vmax_r;
  logic [9:0]  tol_r;
  logic [6:0]  duty_r;
  logic [15:0] tmo_r, defest_r;

  logic [2:0]  mode_r, mode_nxt;
  logic [11:0] pos_r, pos_nxt;
  logic [3:0]  bad_r, bad_nxt;
  logic [15:0] el_r, el_nxt;
  logic [31:0] est_r, est_nxt;
  logic        on_r, on_nxt, dir_r, dir_nxt, ok_nxt, ok_r;
  logic        need_r, need_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [11:0] trav_r, trav_nxt;
  out_item_t   res_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r <= 12'd200; push_r <= 12'd3800; tol_r <= 10'd100; duty_r <= 7'd80;
      tmo_r <= 16'd5000; vmin_r <= 12'd50; vmax_r <= 12'd4000; defest_r <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RELEASED: rel_r <= cfg_data[11:0];
        REG_PUSHED:   push_r <= cfg_data[11:0];
        REG_TOL:      tol_r <= cfg_data[9:0];
        REG_DUTY:     duty_r <= cfg_data[6:0];
        REG_TIMEOUT:  tmo_r <= cfg_data;
        REG_VMIN:     vmin_r <= cfg_data[11:0];
        REG_VMAX:     vmax_r <= cfg_data[11:0];
        REG_DEFEST:   defest_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state update for one item
  logic        s_valid, p_valid;
  logic [11:0] p2;
  logic [3:0]  b2;
  logic        stop2;
  logic [15:0] el_inc;
  logic signed [13:0] pos_s, rel_s, push_s, tol_s;
  logic [12:0] tot, rem;
  logic signed [13:0] trav;
  logic        drv;

  always_comb begin
    mode_nxt = mode_r; pos_nxt = pos_r; bad_nxt = bad_r; el_nxt = el_r;
    est_nxt = est_r; on_nxt = on_r; dir_nxt = dir_r; ok_nxt = 1'b0;
    need_nxt = 1'b0; rem_nxt = rem_r; trav_nxt = trav_r;
    // sample path, shared by sample and clear items
    s_valid = item.sample >= vmin_r && item.sample <= vmax_r;
    b2 = (item.func == FUNC_CLEAR) ? 4'd0 : bad_r;
    stop2 = 1'b0;
    if (s_valid) begin
      p2 = item.sample; b2 = 4'd0;
    end else begin
      p2 = pos_r;
      if (b2 != 4'd15) b2 = b2 + 4'd1;
      stop2 = b2 >= LIMIT;
    end
    p_valid = p2 >= vmin_r && p2 <= vmax_r;
    el_inc = (el_r == 16'hFFFF) ? el_r : el_r + 16'd1;
    pos_s = 14'(pos_r); rel_s = 14'(rel_r); push_s = 14'(push_r); tol_s = 14'(tol_r);
    tot = (push_r > rel_r) ? 13'(push_r - rel_r) : 13'(rel_r - push_r);
    rem = '0;
    if (mode_r == MODE_PUSHING)
      rem = (push_r > pos_r) ? 13'(push_r - pos_r) : 13'(pos_r - push_r);
    else
      rem = (rel_r > pos_r) ? 13'(rel_r - pos_r) : 13'(pos_r - rel_r);
    trav = $signed({1'b0, tot}) - $signed({1'b0, rem});
    drv = mode_r == MODE_PUSHING || mode_r == MODE_RELEASING;
    case (item.func)
      FUNC_TICK: begin
        el_nxt = el_inc;
        if (drv && el_inc > tmo_r) begin
          mode_nxt = MODE_STOPPED; on_nxt = 1'b0; dir_nxt = 1'b0;
        end else if (drv) begin
          // estimate
          if (tot == '0) est_nxt = '0;
          else if (el_inc != '0) begin
            if (trav > 0) begin
              need_nxt = 1'b1; rem_nxt = rem[11:0]; trav_nxt = trav[11:0];
            end else est_nxt = {16'd0, defest_r};
          end
          if (mode_r == MODE_PUSHING) begin
            if (pos_s >= push_s - tol_s) begin
              mode_nxt = MODE_PUSHED; on_nxt = 1'b0; dir_nxt = 1'b0;
            end else begin
              on_nxt = 1'b1; dir_nxt = 1'b1;
            end
          end else begin
            if (pos_s <= rel_s + tol_s) begin
              mode_nxt = MODE_RELEASED; on_nxt = 1'b0; dir_nxt = 1'b0;
            end else begin
              on_nxt = 1'b1; dir_nxt = 1'b0;
            end
          end
        end else begin
          on_nxt = 1'b0; dir_nxt = 1'b0; est_nxt = '0;
        end
      end
      FUNC_SAMPLE: begin
        pos_nxt = p2; bad_nxt = b2;
        if (stop2) begin
          mode_nxt = MODE_STOPPED; on_nxt = 1'b0; dir_nxt = 1'b0;
        end
      end
      FUNC_CMD: begin
        if (!(mode_r == MODE_STOPPED && bad_r >= LIMIT)) begin
          if (!item.command) begin
            if (mode_r != MODE_PUSHING && mode_r != MODE_PUSHED) begin
              mode_nxt = MODE_PUSHING; el_nxt = '0; est_nxt = {16'd0, defest_r};
            end
          end else if (mode_r != MODE_RELEASING && mode_r != MODE_RELEASED) begin
            mode_nxt = MODE_RELEASING; el_nxt = '0; est_nxt = {16'd0, defest_r};
          end
        end
      end
      FUNC_ESTOP: begin
        mode_nxt = MODE_STOPPED; on_nxt = 1'b0; dir_nxt = 1'b0;
      end
      FUNC_CLEAR: begin
        pos_nxt = p2; bad_nxt = b2;
        if (stop2) begin
          mode_nxt = MODE_STOPPED; on_nxt = 1'b0; dir_nxt = 1'b0;
        end
        if (p_valid) begin
          ok_nxt = 1'b1;
          if ($signed(14'(p2)) <= rel_s + tol_s) mode_nxt = MODE_RELEASED;
          else if ($signed(14'(p2)) >= push_s - tol_s) mode_nxt = MODE_PUSHED;
          else mode_nxt = MODE_RELEASED;
        end
      end
      default: ;
    endcase
  end

  // shared divider: estimate quotient then percent quotient
  logic        div_start, div_busy;
  logic [18:0] div_a, div_q;
  logic [12:0] div_b;
  logic [27:0] est_prod;
  assign div_start = cmd.est_start | cmd.pct_start;
  always_comb begin
    if (cmd.est_start) begin
      div_a = {3'd0, el_r}; div_b = {1'b0, trav_r};
    end else begin
      div_a = 19'(pos_r - rel_r) * 19'd100; div_b = 13'(push_r - rel_r);
    end
  end
  bac_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );
  assign est_prod = div_q[15:0] * rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RELEASED; pos_r <= '0; bad_r <= '0; el_r <= '0;
      est_r <= 32'd2000; on_r <= 1'b0; dir_r <= 1'b0; ok_r <= 1'b0; need_r <= 1'b0;
    end else if (cmd.load) begin
      mode_r <= mode_nxt; pos_r <= pos_nxt; bad_r <= bad_nxt; el_r <= el_nxt;
      est_r <= est_nxt; on_r <= on_nxt; dir_r <= dir_nxt; ok_r <= ok_nxt;
      need_r <= need_nxt;
    end else if (cmd.est_fin) begin
      est_r <= {4'd0, est_prod};
    end
    if (cmd.load) begin
      rem_r <= rem_nxt; trav_r <= trav_nxt;
    end
  end

  // result formatting
  logic [31:0] diff;
  logic [6:0]  pct;
  always_comb begin
    diff = est_r - {16'd0, el_r};
    if (pos_r <= rel_r) pct = 7'd0;
    else if (pos_r >= push_r) pct = 7'd100;
    else pct = div_q[6:0];
  end
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r.brake_mode <= mode_r;
      res_r.motor_enable <= on_r;
      res_r.push_direction <= on_r & dir_r;
      res_r.duty_out <= on_r ? ((duty_r > 7'd100) ? 7'd100 : duty_r) : 7'd0;
      res_r.time_to_end <= ((mode_r == MODE_PUSHING || mode_r == MODE_RELEASING) &&
                            {16'd0, el_r} < est_r) ?
                           ((diff > 32'd65535) ? 16'hFFFF : diff[15:0]) : 16'd0;
      res_r.position_percent <= pct;
      res_r.error_flag <= bad_r >= LIMIT;
      res_r.clear_ok <= ok_r;
    end
  end

  assign sts.need_est = need_r;
  assign sts.div_busy = div_busy;
  assign result = res_r;
endmodule
`default_nettype wire

// ===== hw/rtl/bac_ctrl.sv =====
// Sequencer: accept, update, divide, hand over the result.
`default_nettype none
module bac_ctrl import bac_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t   cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EST  = 3'd1;
  localparam logic [2:0] S_ESTW = 3'd2;
  localparam logic [2:0] S_ESTF = 3'd3;
  localparam logic [2:0] S_PCT  = 3'd4;
  localparam logic [2:0] S_PCTW = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       acc;

  // one item in flight; next one taken once the result register is free
  assign in_ready = state_r == S_IDLE && !ov_r;
  assign acc = in_valid && in_ready;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r && !out_ready;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (acc) begin
        cmd.load = 1'b1; state_nxt = S_EST;
      end
      S_EST: begin
        if (sts.need_est) begin
          cmd.est_start = 1'b1; state_nxt = S_ESTW;
        end else state_nxt = S_PCT;
      end
      S_ESTW: if (!sts.div_busy) state_nxt = S_ESTF;
      S_ESTF: begin
        cmd.est_fin = 1'b1; state_nxt = S_PCT;
      end
      S_PCT: begin
        cmd.pct_start = 1'b1; state_nxt = S_PCTW;
      end
      S_PCTW: if (!sts.div_busy) state_nxt = S_RES;
      S_RES: begin
        cmd.res_load = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/brake_actuator_controller_core.sv =====
// Top level of the brake actuator controller.
// Each transaction on in_ carries a tick, sample, command, stop or clear, and
// produces one result on out_. Items are handled one at a time; a shared
// divider computes the estimate quotient, when a tick needs one, and then
// the position percent. Configuration is written through cfg_; the user must
// write it only while idle, as the block does not enforce this.
`default_nettype none
module brake_actuator_controller_core import bac_pkg::*; #(
  parameter int ERROR_LIMIT = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  bac_in_if.sink                in_ch,
  bac_out_if.source             out_ch
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  bac_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
  );

  bac_datapath #(.ERROR_LIMIT(ERROR_LIMIT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(in_ch.data), .cmd(cmd), .sts(sts),
    .result(out_ch.data)
  );

  // no acceptance while a result waits
  a_no_acc_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken with result pending");
  // result appears only after a result load
  a_res_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.res_load)) else $error("result without load");
  // divider never restarted while running
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.est_start || cmd.pct_start) |-> !sts.div_busy) else $error("divider restart");
endmodule
`default_nettype wire
